### hdl/mandelbrot_escape_time_core_defines.svh
// Assertion macros for the Mandelbrot escape-time core.
`ifndef MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Plain property, sampled on clk and disabled in reset.
`define MET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle, consequent in the next.
`define MET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MET_ASSERT(lbl, prop, msg)
`define MET_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/met_pkg.sv
// Types and fixed constants of the Mandelbrot escape-time core.
package met_pkg;

  localparam int CFG_W   = 13;
  localparam int LIMIT_W = 16;
  localparam int CNT_W   = 16;
  localparam int TOTAL_W = 48;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  localparam logic [CFG_W-1:0]   WIDTH_RST  = 13'd800;
  localparam logic [CFG_W-1:0]   HEIGHT_RST = 13'd800;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 16'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAP,
    ST_MUL,
    ST_UPD,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    OP_RR,
    OP_II,
    OP_RI
  } op_t;

endpackage

### hdl/mandelbrot_escape_time_core.sv
// Mandelbrot escape-time core: coordinate mapping divider, shared multiplier, sequencer.
//
// Input channel (in_valid/in_ready) takes one pixel item: column, row and a
// frame-start flag that clears the running total before this pixel is added.
// Output channel (out_valid/out_ready) returns the escape count and the
// saturating 48-bit running total. Registers sit on an APB-style port.
// in_ready is high only while the sequencer is idle; one item is worked on at
// a time. Per item: the restoring divider maps re and im, one quotient bit a
// cycle, into NW quotient bits, NW = max(COORD_BITS+2,14)+FRAC_BITS (42 at the
// defaults). Each iteration then runs three products (zr*zr, zi*zi, zr*zi) on
// the one multiplier, each of P partial products, P = 1 for Q widths up to 32
// bits, else 4; the escaping iteration stops before its zr*zi product. The
// finish step then loads the output register.
// The output register lets a new item be accepted while a result waits; a
// finished item holds in its last state until the output register is free.
// Synchronous reset returns the registers to 800/800/1000, clears the total
// and empties the output register; an item in progress is dropped.
`include "mandelbrot_escape_time_core_defines.svh"
module mandelbrot_escape_time_core import met_pkg::*; #(
  parameter int FRAC_BITS  = 28,
  parameter int COORD_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pixel_col,
  input  logic [COORD_BITS-1:0] in_pixel_row,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CNT_W-1:0]      out_escape_count,
  output logic [TOTAL_W-1:0]    out_count_total,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int QW   = FRAC_BITS + 4;
  localparam int MW   = QW;
  localparam int NCH  = (MW > 32) ? 2 : 1;
  localparam int HW   = (MW + NCH - 1) / NCH;
  localparam int AW   = 2 * NCH * HW;
  localparam int PW   = FRAC_BITS + 7;
  localparam int EW   = FRAC_BITS + 10;
  localparam int MAGW = (COORD_BITS + 2 > 14) ? COORD_BITS + 2 : 14;
  localparam int NW   = MAGW + FRAC_BITS;
  localparam int DCW  = $clog2(NW);

  localparam logic [0:0]              CI_LAST = 1'(NCH - 1);
  localparam logic [DCW-1:0]          DCNT_LOAD = DCW'(NW - 1);
  localparam logic signed [QW-1:0]    Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0]    Q_MIN = {1'b1, {(QW-1){1'b0}}};
  localparam logic signed [EW-1:0]    EXT_QMAX = EW'(Q_MAX);
  localparam logic signed [EW-1:0]    EXT_QMIN = EW'(Q_MIN);
  localparam logic [NW-1:0]           QHALF = NW'(1) << (FRAC_BITS + 3);
  localparam logic [PW:0]             FOUR = (PW+1)'(1) << (FRAC_BITS + 2);
  localparam logic [TOTAL_W-1:0]      TOTAL_MAX = {TOTAL_W{1'b1}};

  function automatic logic signed [QW-1:0] sat_q(input logic signed [EW-1:0] v);
    if (v > EXT_QMAX) return Q_MAX;
    else if (v < EXT_QMIN) return Q_MIN;
    else return v[QW-1:0];
  endfunction

  function automatic logic [MW-1:0] q_abs(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] n;
    n = -v;
    return v[QW-1] ? MW'(n) : MW'(v);
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic                     ci_r, ci_nxt, cj_r, cj_nxt;
  logic [AW-1:0]            acc_r, acc_nxt;
  logic signed [QW-1:0]     zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [QW-1:0]     cre_r, cre_nxt, cim_r, cim_nxt;
  logic [PW-1:0]            r2_r, r2_nxt, i2_r, i2_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CFG_W-1:0]         rem_r, rem_nxt;
  logic [NW-1:0]            dvd_r, dvd_nxt;
  logic [DCW-1:0]           dcnt_r, dcnt_nxt;
  logic                     im_sel_r, im_sel_nxt, neg_r, neg_nxt;
  logic [COORD_BITS-1:0]    y_r, y_nxt;
  logic                     fs_r, fs_nxt;
  logic [CFG_W-1:0]         width_r, width_nxt, height_r, height_nxt;
  logic [LIMIT_W-1:0]       limit_r, limit_nxt;
  logic [TOTAL_W-1:0]       total_r, total_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]         out_count_r, out_count_nxt;
  logic [TOTAL_W-1:0]       out_total_r, out_total_nxt;

  // coordinate numerator and divider load value
  logic [COORD_BITS-1:0]    sel_p;
  logic [CFG_W-1:0]         sel_s;
  logic signed [MAGW:0]     num;
  logic [MAGW:0]            num_abs;
  logic [NW-1:0]            dvd_load;

  // divider step
  logic [CFG_W-1:0]         dvs;
  logic [CFG_W:0]           div_t, div_sub;
  logic                     div_ge;

  // mapping result
  logic                     q_big;
  logic signed [QW-1:0]     q_low, map_val;

  // multiplier
  logic signed [QW-1:0]     op_a, op_b;
  logic [NCH*HW-1:0]        ma_ext, mb_ext, ma_sh, mb_sh;
  logic [HW-1:0]            a_chunk, b_chunk;
  logic [2*HW-1:0]          pp;
  logic [AW-1:0]            pp_sh;
  logic                     first_pp, last_pp;
  logic [PW-1:0]            prod_mag;
  logic [PW:0]              mag_sum;
  logic                     escaped;

  // update
  logic signed [EW-1:0]     r2_e, i2_e, ri_e, ri_s, cre_e, cim_e;
  logic signed [QW-1:0]     zr_new, zi_new;
  logic [CNT_W-1:0]         count_inc;

  logic [TOTAL_W:0]         total_sum;
  logic [TOTAL_W-1:0]       total_base;
  logic                     cfg_wr, fin_load;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_escape_count = out_count_r;
  assign out_count_total  = out_total_r;
  assign pready           = 1'b1;
  assign cfg_wr           = psel && penable && pwrite;
  assign fin_load         = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      REG_LIMIT:  prdata = DATA_W'(limit_r);
      default:    prdata = '0;
    endcase
  end

  // |4p - 2s| << FRAC_BITS; the idle cycle loads re, the re map cycle loads im
  assign sel_p    = (state_r == ST_IDLE) ? in_pixel_col : y_r;
  assign sel_s    = (state_r == ST_IDLE) ? width_r : height_r;
  assign num      = $signed((MAGW+1)'({sel_p, 2'b00})) - $signed((MAGW+1)'({sel_s, 1'b0}));
  assign num_abs  = num[MAGW] ? -num : num;
  assign dvd_load = {num_abs[MAGW-1:0], {FRAC_BITS{1'b0}}};

  // restoring division, one quotient bit a cycle; zero width divides as one
  assign dvs     = (width_r == '0) ? CFG_W'(1) : width_r;
  assign div_t   = {rem_r, dvd_r[NW-1]};
  assign div_sub = div_t - {1'b0, dvs};
  assign div_ge  = (div_t >= {1'b0, dvs});

  // quotient to Q4, toward zero, saturated
  assign q_big   = (dvd_r >= QHALF);
  assign q_low   = dvd_r[QW-1:0];
  assign map_val = neg_r ? (q_big ? Q_MIN : -q_low) : (q_big ? Q_MAX : q_low);

  // one partial product a cycle on magnitudes; sign applied when taken
  assign op_a     = (op_r == OP_II) ? zi_r : zr_r;
  assign op_b     = (op_r == OP_RR) ? zr_r : zi_r;
  assign ma_ext   = (NCH*HW)'(q_abs(op_a));
  assign mb_ext   = (NCH*HW)'(q_abs(op_b));
  assign ma_sh    = ma_ext >> (HW * ci_r);
  assign mb_sh    = mb_ext >> (HW * cj_r);
  assign a_chunk  = ma_sh[HW-1:0];
  assign b_chunk  = mb_sh[HW-1:0];
  assign pp       = a_chunk * b_chunk;
  assign pp_sh    = AW'(pp) << (HW * (32'(ci_r) + 32'(cj_r)));
  assign first_pp = !ci_r && !cj_r;
  assign last_pp  = (ci_r == CI_LAST) && (cj_r == CI_LAST);
  assign prod_mag = acc_r[FRAC_BITS +: PW];
  assign mag_sum  = {1'b0, r2_r} + {1'b0, prod_mag};
  assign escaped  = (mag_sum >= FOUR);

  assign r2_e      = EW'(r2_r);
  assign i2_e      = EW'(i2_r);
  assign ri_e      = EW'(prod_mag);
  assign ri_s      = (zr_r[QW-1] ^ zi_r[QW-1]) ? -ri_e : ri_e;
  assign cre_e     = EW'(cre_r);
  assign cim_e     = EW'(cim_r);
  assign zr_new    = sat_q(r2_e - i2_e + cre_e);
  assign zi_new    = sat_q((ri_s <<< 1) + cim_e);
  assign count_inc = count_r + 1'b1;

  assign total_base = fs_r ? '0 : total_r;
  assign total_sum  = {1'b0, total_base} + (TOTAL_W+1)'(count_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV:  if (dcnt_r == '0) state_nxt = ST_MAP;
      ST_MAP: begin
        if (!im_sel_r) state_nxt = ST_DIV;
        else if (limit_r == '0) state_nxt = ST_FIN;
        else state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (op_r == OP_RI && first_pp && escaped) state_nxt = ST_FIN;
        else if (op_r == OP_RI && last_pp) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (count_inc >= limit_r) state_nxt = ST_FIN;
        else state_nxt = ST_MUL;
      end
      ST_FIN:  if (fin_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_nxt        = op_r;
    ci_nxt        = ci_r;
    cj_nxt        = cj_r;
    acc_nxt       = acc_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    cre_nxt       = cre_r;
    cim_nxt       = cim_r;
    r2_nxt        = r2_r;
    i2_nxt        = i2_r;
    count_nxt     = count_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    dcnt_nxt      = dcnt_r;
    im_sel_nxt    = im_sel_r;
    neg_nxt       = neg_r;
    y_nxt         = y_r;
    fs_nxt        = fs_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r;
    out_count_nxt = out_count_r;
    out_total_nxt = out_total_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    limit_nxt     = limit_r;

    if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  width_nxt  = pwdata[CFG_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[CFG_W-1:0];
        REG_LIMIT:  limit_nxt  = pwdata[LIMIT_W-1:0];
        default:    ;
      endcase
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          y_nxt      = in_pixel_row;
          fs_nxt     = in_frame_start;
          im_sel_nxt = 1'b0;
          neg_nxt    = num[MAGW];
          rem_nxt    = '0;
          dvd_nxt    = dvd_load;
          dcnt_nxt   = DCNT_LOAD;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_sub[CFG_W-1:0] : div_t[CFG_W-1:0];
        dvd_nxt  = {dvd_r[NW-2:0], div_ge};
        dcnt_nxt = dcnt_r - 1'b1;
      end
      ST_MAP: begin
        if (!im_sel_r) begin
          cre_nxt    = map_val;
          im_sel_nxt = 1'b1;
          neg_nxt    = num[MAGW];
          rem_nxt    = '0;
          dvd_nxt    = dvd_load;
          dcnt_nxt   = DCNT_LOAD;
        end else begin
          cim_nxt   = map_val;
          zr_nxt    = '0;
          zi_nxt    = '0;
          count_nxt = '0;
          op_nxt    = OP_RR;
          ci_nxt    = 1'b0;
          cj_nxt    = 1'b0;
        end
      end
      ST_MUL: begin
        acc_nxt = (first_pp ? '0 : acc_r) + pp_sh;
        // the first cycle of an op sees the previous op's product in acc_r
        if (first_pp && op_r == OP_II) r2_nxt = prod_mag;
        if (first_pp && op_r == OP_RI) i2_nxt = prod_mag;
        if (last_pp) begin
          ci_nxt = 1'b0;
          cj_nxt = 1'b0;
          case (op_r)
            OP_RR:   op_nxt = OP_II;
            OP_II:   op_nxt = OP_RI;
            default: op_nxt = OP_RR;
          endcase
        end else if (cj_r == CI_LAST) begin
          cj_nxt = 1'b0;
          ci_nxt = 1'b1;
        end else begin
          cj_nxt = 1'b1;
        end
      end
      ST_UPD: begin
        zr_nxt    = zr_new;
        zi_nxt    = zi_new;
        count_nxt = count_inc;
        op_nxt    = OP_RR;
        ci_nxt    = 1'b0;
        cj_nxt    = 1'b0;
      end
      ST_FIN: begin
        if (fin_load) begin
          total_nxt     = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_total_nxt = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      total_r     <= '0;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
      limit_r     <= LIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      total_r     <= total_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      limit_r     <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ci_r        <= ci_nxt;
    cj_r        <= cj_nxt;
    acc_r       <= acc_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    cre_r       <= cre_nxt;
    cim_r       <= cim_nxt;
    r2_r        <= r2_nxt;
    i2_r        <= i2_nxt;
    count_r     <= count_nxt;
    rem_r       <= rem_nxt;
    dvd_r       <= dvd_nxt;
    dcnt_r      <= dcnt_nxt;
    im_sel_r    <= im_sel_nxt;
    neg_r       <= neg_nxt;
    y_r         <= y_nxt;
    fs_r        <= fs_nxt;
    out_count_r <= out_count_nxt;
    out_total_r <= out_total_nxt;
  end

  `MET_ASSERT_NEXT(a_accept_starts_div, in_valid && in_ready, state_r == ST_DIV, "item accepted but divider not started")
  `MET_ASSERT(a_out_from_fin, $rose(out_valid_r) |-> $past(state_r) == ST_FIN, "result shown outside the finish step")
  `MET_ASSERT_NEXT(a_total_monotonic, fin_load && !fs_r, total_r >= $past(total_r), "running total fell without frame start")

endmodule
